/* rtl/fcba_pkg.sv */
// Shared types, widths and codes of the chained block allocator.
package fcba_pkg;

  // Store geometry.
  localparam int TOTAL_BLOCKS = 4096;
  localparam int MAX_FILES    = 1024;
  localparam int BLK_W        = $clog2(TOTAL_BLOCKS);
  localparam int LINK_W       = BLK_W + 1;
  localparam int FID_W        = $clog2(MAX_FILES);
  localparam int ID_W         = FID_W + 1;
  localparam int AMT_W        = 28;
  localparam int BS_W         = 16;
  localparam int RSV_W        = 12;
  localparam int PROD_W       = AMT_W + BS_W;
  localparam int DIV_STEP_W   = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(TOTAL_BLOCKS);
  localparam logic [AMT_W-1:0]  SIZE_LIMIT = {AMT_W{1'b1}};
  localparam logic [BS_W-1:0]   BS_RESET   = BS_W'(1024);
  localparam logic [RSV_W-1:0]  RSV_RESET  = RSV_W'(16);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED   = 1'b1;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_EXTEND = 2'd1,
    ACT_ACCESS = 2'd2,
    ACT_SHRINK = 2'd3
  } action_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_DIV_AMT,
    OP_DIV_SIZE,
    OP_MUL,
    OP_CNT_SET,
    OP_SCAN_RD,
    OP_CNT_CK,
    OP_GRAB_SET,
    OP_GRAB_CK,
    OP_GRAB_END,
    OP_WALK_SET,
    OP_WALK_RD,
    OP_WALK_WT,
    OP_CUT_RD,
    OP_CUT_WT,
    OP_FREE_RD,
    OP_CUT_END,
    OP_COMMIT,
    OP_PASS,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    clr_done;
    logic    div_busy;
    logic    have_file;
    logic    amt_le_avail;
    logic    amt_le_size;
    logic    need_ok;
    logic    need_zero;
    logic    shrink_ok;
    logic    grown_ok;
    logic    amt_zero;
    logic    scan_end;
    logic    space_ok;
    logic    walk_end;
    logic    cur_valid;
    logic    grab_end;
    logic    out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIV_WAIT,
    S_NEED_CHK,
    S_MUL,
    S_MUL_CHK,
    S_CNT_SET,
    S_CNT_RD,
    S_CNT_CK,
    S_SPACE_CHK,
    S_WALK_SET,
    S_WALK_RD,
    S_WALK_WT,
    S_GRAB_SET,
    S_GRAB_RD,
    S_GRAB_CK,
    S_GRAB_END,
    S_CUT_RD,
    S_CUT_WT,
    S_FREE_RD,
    S_FREE_WT,
    S_CUT_END,
    S_COMMIT,
    S_ACCEPT,
    S_REJECT,
    S_DONE
  } ctrl_state_t;

endpackage

/* rtl/fcba_if.sv */
// Handshake channel interfaces for requests and results.
interface fcba_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [fcba_pkg::FID_W-1:0]    file_id;
  logic [fcba_pkg::AMT_W-1:0]    amount;
  modport source (output valid, action, file_id, amount, input ready);
  modport sink (input valid, action, file_id, amount, output ready);
endinterface

interface fcba_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [fcba_pkg::BLK_W-1:0]    block_index;
  logic [fcba_pkg::FID_W-1:0]    new_file_id;
  modport source (output valid, status, block_index, new_file_id, input ready);
  modport sink (input valid, status, block_index, new_file_id, output ready);
endinterface

/* rtl/fcba_div.sv */
// Restoring divider, one quotient bit per cycle, giving the rounded-up quotient.
module fcba_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fcba_pkg::AMT_W-1:0] dividend,
  input  logic [fcba_pkg::BS_W-1:0]  divisor,
  output logic                       busy,
  output logic [fcba_pkg::AMT_W-1:0] ceil_q
);

  logic                            busy_r;
  logic [fcba_pkg::DIV_STEP_W-1:0] step_r;
  logic [fcba_pkg::AMT_W-1:0]      quo_r;
  logic [fcba_pkg::BS_W-1:0]       rem_r;
  logic [fcba_pkg::BS_W-1:0]       dsr_r;
  logic [fcba_pkg::BS_W:0]         shifted;
  logic                            ge;

  // Shift in the next dividend bit and trial-subtract.
  assign shifted = {rem_r, quo_r[fcba_pkg::AMT_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == fcba_pkg::DIV_STEP_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= fcba_pkg::DIV_STEP_W'(fcba_pkg::AMT_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      step_r <= step_r - fcba_pkg::DIV_STEP_W'(1);
      quo_r  <= {quo_r[fcba_pkg::AMT_W-2:0], ge};
      rem_r  <= ge ? fcba_pkg::BS_W'(shifted - {1'b0, dsr_r}) : shifted[fcba_pkg::BS_W-1:0];
    end
  end

  assign busy   = busy_r;
  assign ceil_q = quo_r + fcba_pkg::AMT_W'(rem_r != '0);

endmodule

/* rtl/fcba_datapath.sv */
// Datapath: link table, free map, directory, counters, divider and result register.
module fcba_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fcba_pkg::dp_cmd_t               cmd,
  output fcba_pkg::dp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [fcba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fcba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                      in_action,
  input  logic [fcba_pkg::FID_W-1:0]      in_file_id,
  input  logic [fcba_pkg::AMT_W-1:0]      in_amount,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_status,
  output logic [fcba_pkg::BLK_W-1:0]      out_block_index,
  output logic [fcba_pkg::FID_W-1:0]      out_new_file_id
);

  localparam int LW = fcba_pkg::LINK_W;
  localparam int BW = fcba_pkg::BLK_W;
  localparam int AW = fcba_pkg::AMT_W;

  // Storage.
  logic [LW-1:0] chain_mem  [fcba_pkg::TOTAL_BLOCKS];
  logic          free_mem   [fcba_pkg::TOTAL_BLOCKS];
  logic [AW-1:0] dsize_mem  [fcba_pkg::MAX_FILES];
  logic [BW-1:0] dstart_mem [fcba_pkg::MAX_FILES];

  logic [fcba_pkg::BS_W-1:0]   bs_r;
  logic [fcba_pkg::RSV_W-1:0]  rsv_r;
  fcba_pkg::action_t           act_r;
  logic [fcba_pkg::FID_W-1:0]  fid_r;
  logic [AW-1:0]               amt_r;
  logic [LW-1:0]               used_r;
  logic [fcba_pkg::ID_W-1:0]   nextid_r;
  logic [LW-1:0]               clr_r;
  logic [AW-1:0]               size_q;
  logic [BW-1:0]               start_q;
  logic [LW-1:0]               chain_q;
  logic                        free_q;
  logic [fcba_pkg::PROD_W-1:0] prod_r;
  logic [LW-1:0]               cnt_r;
  logic [LW-1:0]               cur_r;
  logic [BW-1:0]               last_r;
  logic [LW-1:0]               scan_r;
  logic [LW-1:0]               n_r;
  logic [LW-1:0]               tail_r;
  logic                        has_tail_r;
  logic [BW-1:0]               first_r;
  logic [LW-1:0]               fcount_r;
  logic                        res_status_r;
  logic [BW-1:0]               res_blk_r;
  logic [fcba_pkg::FID_W-1:0]  res_nid_r;
  logic                        out_valid_r;
  logic                        out_status_r;
  logic [BW-1:0]               out_blk_r;
  logic [fcba_pkg::FID_W-1:0]  out_nid_r;

  logic [fcba_pkg::BS_W-1:0]   bs_eff;
  logic [LW-1:0]               room;
  logic [LW-1:0]               avail;
  logic [AW-1:0]               need;
  logic                        div_busy;
  logic                        div_start;
  logic [AW-1:0]               div_dividend;
  logic [AW:0]                 grown;
  logic [AW-1:0]               hops;
  logic [LW-1:0]               hops_cap;
  logic                        walk_end;
  fcba_pkg::dp_op_t            op;

  assign op     = cmd.op;
  assign bs_eff = (bs_r == '0) ? fcba_pkg::BS_W'(1) : bs_r;

  // Blocks still available above the reserved area, floored at zero.
  assign room  = LW'(fcba_pkg::TOTAL_BLOCKS) - {1'b0, rsv_r};
  assign avail = (used_r >= room) ? '0 : room - used_r;

  // Shared rounding-up divider by the block size.
  assign div_start    = (op == fcba_pkg::OP_DIV_AMT) || (op == fcba_pkg::OP_DIV_SIZE);
  assign div_dividend = (op == fcba_pkg::OP_DIV_AMT) ? amt_r : size_q;

  fcba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bs_eff),
    .busy     (div_busy),
    .ceil_q   (need)
  );

  assign grown = {1'b0, size_q} + (AW + 1)'(prod_r);

  // Hop count of the chain walk for each operation, capped at the store size.
  always_comb begin
    case (act_r)
      fcba_pkg::ACT_EXTEND: hops = need - AW'(1);
      fcba_pkg::ACT_ACCESS: hops = (need == '0) ? '0 : need - AW'(1);
      fcba_pkg::ACT_SHRINK: hops = need - amt_r - AW'(1);
      default:              hops = '0;
    endcase
  end
  assign hops_cap = (hops > AW'(fcba_pkg::TOTAL_BLOCKS)) ? LW'(fcba_pkg::TOTAL_BLOCKS)
                                                          : hops[LW-1:0];
  assign walk_end = (cnt_r == '0) || cur_r[LW-1];

  // Status to the controller.
  always_comb begin
    stat.act          = act_r;
    stat.clr_done     = clr_r[LW-1];
    stat.div_busy     = div_busy;
    stat.have_file    = size_q != '0;
    stat.amt_le_avail = amt_r <= AW'(avail);
    stat.amt_le_size  = amt_r <= size_q;
    stat.need_ok      = (nextid_r < fcba_pkg::ID_W'(fcba_pkg::MAX_FILES)) && (need <= AW'(avail));
    stat.need_zero    = need == '0;
    stat.shrink_ok    = amt_r <= need - AW'(1);
    stat.grown_ok     = grown <= (AW + 1)'(fcba_pkg::SIZE_LIMIT);
    stat.amt_zero     = amt_r == '0;
    stat.scan_end     = scan_r[LW-1];
    stat.space_ok     = (act_r == fcba_pkg::ACT_CREATE) ? (AW'(fcount_r) >= need)
                                                        : (AW'(fcount_r) >= amt_r);
    stat.walk_end     = walk_end;
    stat.cur_valid    = !cur_r[LW-1];
    stat.grab_end     = scan_r[LW-1] || (n_r == '0);
    stat.out_busy     = out_valid_r && !out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= fcba_pkg::BS_RESET;
      rsv_r <= fcba_pkg::RSV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fcba_pkg::REG_BLOCK_SIZE: bs_r  <= cfg_data;
        fcba_pkg::REG_RESERVED:   rsv_r <= cfg_data[fcba_pkg::RSV_W-1:0];
        default: ;
      endcase
    end
  end

  // Control counters: clearing sweep, block usage and id allocation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      used_r   <= '0;
      nextid_r <= '0;
    end else begin
      if (op == fcba_pkg::OP_CLEAR) begin
        clr_r <= clr_r + LW'(1);
      end
      if (op == fcba_pkg::OP_COMMIT) begin
        case (act_r)
          fcba_pkg::ACT_CREATE: begin
            used_r   <= used_r + need[LW-1:0];
            nextid_r <= nextid_r + fcba_pkg::ID_W'(1);
          end
          fcba_pkg::ACT_EXTEND: used_r <= used_r + amt_r[LW-1:0];
          fcba_pkg::ACT_SHRINK: used_r <= (AW'(used_r) >= amt_r) ? used_r - amt_r[LW-1:0] : '0;
          default: ;
        endcase
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (op)
      fcba_pkg::OP_LATCH: begin
        act_r        <= fcba_pkg::action_t'(in_action);
        fid_r        <= in_file_id;
        amt_r        <= in_amount;
        res_status_r <= 1'b1;
        res_blk_r    <= '0;
        res_nid_r    <= '0;
      end
      fcba_pkg::OP_MUL:      prod_r <= amt_r * bs_eff;
      fcba_pkg::OP_CNT_SET: begin
        scan_r   <= {1'b0, rsv_r};
        fcount_r <= '0;
      end
      fcba_pkg::OP_CNT_CK: begin
        fcount_r <= fcount_r + LW'(free_q);
        scan_r   <= scan_r + LW'(1);
      end
      fcba_pkg::OP_GRAB_SET: begin
        scan_r     <= {1'b0, rsv_r};
        n_r        <= (act_r == fcba_pkg::ACT_CREATE) ? need[LW-1:0] : amt_r[LW-1:0];
        tail_r     <= cur_r;
        has_tail_r <= act_r == fcba_pkg::ACT_EXTEND;
        first_r    <= '0;
      end
      fcba_pkg::OP_GRAB_CK: begin
        if (free_q) begin
          n_r        <= n_r - LW'(1);
          tail_r     <= scan_r;
          has_tail_r <= 1'b1;
          if (!has_tail_r) begin
            first_r <= scan_r[BW-1:0];
          end
        end
        scan_r <= scan_r + LW'(1);
      end
      fcba_pkg::OP_WALK_SET: begin
        cur_r <= {1'b0, start_q};
        cnt_r <= hops_cap;
      end
      fcba_pkg::OP_WALK_WT: begin
        cur_r <= chain_q;
        cnt_r <= cnt_r - LW'(1);
      end
      fcba_pkg::OP_CUT_RD: begin
        last_r <= cur_r[BW-1:0];
        cnt_r  <= LW'(fcba_pkg::TOTAL_BLOCKS);
      end
      fcba_pkg::OP_CUT_WT:   cur_r <= chain_q;
      fcba_pkg::OP_COMMIT: begin
        if (act_r == fcba_pkg::ACT_CREATE) begin
          res_nid_r <= nextid_r[fcba_pkg::FID_W-1:0];
        end
      end
      fcba_pkg::OP_PASS: begin
        res_status_r <= 1'b0;
        if (act_r == fcba_pkg::ACT_ACCESS) begin
          res_blk_r <= cur_r[BW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Directory store: a read at item entry, a size clear per sweep step below MAX_FILES, and writes at commit.
  always_ff @(posedge clk) begin
    if (op == fcba_pkg::OP_LATCH) begin
      size_q  <= dsize_mem[in_file_id];
      start_q <= dstart_mem[in_file_id];
    end
    if (op == fcba_pkg::OP_CLEAR && clr_r < LW'(fcba_pkg::MAX_FILES)) begin
      dsize_mem[clr_r[fcba_pkg::FID_W-1:0]] <= '0;
    end else if (op == fcba_pkg::OP_COMMIT) begin
      case (act_r)
        fcba_pkg::ACT_CREATE: begin
          dsize_mem[nextid_r[fcba_pkg::FID_W-1:0]]  <= amt_r;
          dstart_mem[nextid_r[fcba_pkg::FID_W-1:0]] <= stat.need_zero ? '0 : first_r;
        end
        fcba_pkg::ACT_EXTEND: dsize_mem[fid_r] <= grown[AW-1:0];
        fcba_pkg::ACT_SHRINK: dsize_mem[fid_r] <= size_q - prod_r[AW-1:0];
        default: ;
      endcase
    end
  end

  // Free map: scan reads, and writes for clearing, allocation and release.
  always_ff @(posedge clk) begin
    case (op)
      fcba_pkg::OP_SCAN_RD: free_q <= free_mem[scan_r[BW-1:0]];
      fcba_pkg::OP_CLEAR:   free_mem[clr_r[BW-1:0]] <= 1'b1;
      fcba_pkg::OP_GRAB_CK: begin
        if (free_q) begin
          free_mem[scan_r[BW-1:0]] <= 1'b0;
        end
      end
      fcba_pkg::OP_FREE_RD: free_mem[cur_r[BW-1:0]] <= 1'b1;
      default: ;
    endcase
  end

  // Link table: walk reads and link writes.
  always_ff @(posedge clk) begin
    case (op)
      fcba_pkg::OP_WALK_RD,
      fcba_pkg::OP_CUT_RD,
      fcba_pkg::OP_FREE_RD: chain_q <= chain_mem[cur_r[BW-1:0]];
      fcba_pkg::OP_GRAB_CK: begin
        if (free_q && has_tail_r && !tail_r[LW-1]) begin
          chain_mem[tail_r[BW-1:0]] <= scan_r;
        end
      end
      fcba_pkg::OP_GRAB_END: begin
        if (has_tail_r && !tail_r[LW-1]) begin
          chain_mem[tail_r[BW-1:0]] <= fcba_pkg::LINK_END;
        end
      end
      fcba_pkg::OP_CUT_END: chain_mem[last_r] <= fcba_pkg::LINK_END;
      default: ;
    endcase
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == fcba_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == fcba_pkg::OP_EMIT) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_nid_r    <= res_nid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_blk_r;
  assign out_new_file_id = out_nid_r;

endmodule

/* rtl/fcba_ctrl.sv */
// Controller state machine sequencing each operation through the datapath.
module fcba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcba_pkg::dp_stat_t stat,
  output fcba_pkg::dp_cmd_t  cmd
);

  fcba_pkg::ctrl_state_t state_r;
  fcba_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcba_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcba_pkg::S_CLEAR:    if (stat.clr_done) state_nxt = fcba_pkg::S_IDLE;
      fcba_pkg::S_IDLE:     if (in_valid) state_nxt = fcba_pkg::S_CHECK;
      fcba_pkg::S_CHECK: begin
        case (stat.act)
          fcba_pkg::ACT_CREATE: state_nxt = fcba_pkg::S_DIV;
          fcba_pkg::ACT_EXTEND: state_nxt = (stat.have_file && stat.amt_le_avail) ?
                                            fcba_pkg::S_MUL : fcba_pkg::S_REJECT;
          fcba_pkg::ACT_ACCESS: state_nxt = (stat.have_file && stat.amt_le_size) ?
                                            fcba_pkg::S_DIV : fcba_pkg::S_REJECT;
          default:              state_nxt = stat.have_file ? fcba_pkg::S_DIV
                                                           : fcba_pkg::S_REJECT;
        endcase
      end
      fcba_pkg::S_DIV:      state_nxt = fcba_pkg::S_DIV_WAIT;
      fcba_pkg::S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = (stat.act == fcba_pkg::ACT_CREATE || stat.act == fcba_pkg::ACT_SHRINK) ?
                      fcba_pkg::S_NEED_CHK : fcba_pkg::S_WALK_SET;
        end
      end
      fcba_pkg::S_NEED_CHK: begin
        if (stat.act == fcba_pkg::ACT_CREATE) begin
          if (!stat.need_ok)      state_nxt = fcba_pkg::S_REJECT;
          else if (stat.need_zero) state_nxt = fcba_pkg::S_COMMIT;
          else                     state_nxt = fcba_pkg::S_CNT_SET;
        end else begin
          state_nxt = stat.shrink_ok ? fcba_pkg::S_MUL : fcba_pkg::S_REJECT;
        end
      end
      fcba_pkg::S_MUL:      state_nxt = fcba_pkg::S_MUL_CHK;
      fcba_pkg::S_MUL_CHK: begin
        if (stat.act == fcba_pkg::ACT_SHRINK) state_nxt = fcba_pkg::S_WALK_SET;
        else if (!stat.grown_ok)              state_nxt = fcba_pkg::S_REJECT;
        else if (stat.amt_zero)               state_nxt = fcba_pkg::S_ACCEPT;
        else                                  state_nxt = fcba_pkg::S_CNT_SET;
      end
      fcba_pkg::S_CNT_SET:  state_nxt = fcba_pkg::S_CNT_RD;
      fcba_pkg::S_CNT_RD:   state_nxt = stat.scan_end ? fcba_pkg::S_SPACE_CHK : fcba_pkg::S_CNT_CK;
      fcba_pkg::S_CNT_CK:   state_nxt = fcba_pkg::S_CNT_RD;
      fcba_pkg::S_SPACE_CHK: begin
        if (!stat.space_ok)                   state_nxt = fcba_pkg::S_REJECT;
        else if (stat.act == fcba_pkg::ACT_CREATE) state_nxt = fcba_pkg::S_GRAB_SET;
        else                                  state_nxt = fcba_pkg::S_DIV;
      end
      fcba_pkg::S_WALK_SET: state_nxt = fcba_pkg::S_WALK_RD;
      fcba_pkg::S_WALK_RD: begin
        if (!stat.walk_end)                   state_nxt = fcba_pkg::S_WALK_WT;
        else if (stat.act == fcba_pkg::ACT_EXTEND) state_nxt = fcba_pkg::S_GRAB_SET;
        else if (stat.act == fcba_pkg::ACT_ACCESS) state_nxt = fcba_pkg::S_ACCEPT;
        else if (stat.cur_valid)              state_nxt = fcba_pkg::S_CUT_RD;
        else                                  state_nxt = fcba_pkg::S_COMMIT;
      end
      fcba_pkg::S_WALK_WT:  state_nxt = fcba_pkg::S_WALK_RD;
      fcba_pkg::S_GRAB_SET: state_nxt = fcba_pkg::S_GRAB_RD;
      fcba_pkg::S_GRAB_RD:  state_nxt = stat.grab_end ? fcba_pkg::S_GRAB_END : fcba_pkg::S_GRAB_CK;
      fcba_pkg::S_GRAB_CK:  state_nxt = fcba_pkg::S_GRAB_RD;
      fcba_pkg::S_GRAB_END: state_nxt = fcba_pkg::S_COMMIT;
      fcba_pkg::S_CUT_RD:   state_nxt = fcba_pkg::S_CUT_WT;
      fcba_pkg::S_CUT_WT:   state_nxt = fcba_pkg::S_FREE_RD;
      fcba_pkg::S_FREE_RD:  state_nxt = stat.walk_end ? fcba_pkg::S_CUT_END : fcba_pkg::S_FREE_WT;
      fcba_pkg::S_FREE_WT:  state_nxt = fcba_pkg::S_FREE_RD;
      fcba_pkg::S_CUT_END:  state_nxt = fcba_pkg::S_COMMIT;
      fcba_pkg::S_COMMIT:   state_nxt = fcba_pkg::S_ACCEPT;
      fcba_pkg::S_ACCEPT:   state_nxt = fcba_pkg::S_DONE;
      fcba_pkg::S_REJECT:   state_nxt = fcba_pkg::S_DONE;
      fcba_pkg::S_DONE:     if (!stat.out_busy) state_nxt = fcba_pkg::S_IDLE;
      default:              state_nxt = fcba_pkg::S_CLEAR;
    endcase
  end

  // Datapath operation and handshake per state.
  always_comb begin
    cmd.op   = fcba_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      fcba_pkg::S_CLEAR:    if (!stat.clr_done) cmd.op = fcba_pkg::OP_CLEAR;
      fcba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = fcba_pkg::OP_LATCH;
      end
      fcba_pkg::S_DIV: begin
        cmd.op = (stat.act == fcba_pkg::ACT_CREATE || stat.act == fcba_pkg::ACT_ACCESS) ?
                 fcba_pkg::OP_DIV_AMT : fcba_pkg::OP_DIV_SIZE;
      end
      fcba_pkg::S_MUL:      cmd.op = fcba_pkg::OP_MUL;
      fcba_pkg::S_CNT_SET:  cmd.op = fcba_pkg::OP_CNT_SET;
      fcba_pkg::S_CNT_RD:   if (!stat.scan_end) cmd.op = fcba_pkg::OP_SCAN_RD;
      fcba_pkg::S_CNT_CK:   cmd.op = fcba_pkg::OP_CNT_CK;
      fcba_pkg::S_WALK_SET: cmd.op = fcba_pkg::OP_WALK_SET;
      fcba_pkg::S_WALK_RD:  if (!stat.walk_end) cmd.op = fcba_pkg::OP_WALK_RD;
      fcba_pkg::S_WALK_WT:  cmd.op = fcba_pkg::OP_WALK_WT;
      fcba_pkg::S_GRAB_SET: cmd.op = fcba_pkg::OP_GRAB_SET;
      fcba_pkg::S_GRAB_RD:  if (!stat.grab_end) cmd.op = fcba_pkg::OP_SCAN_RD;
      fcba_pkg::S_GRAB_CK:  cmd.op = fcba_pkg::OP_GRAB_CK;
      fcba_pkg::S_GRAB_END: cmd.op = fcba_pkg::OP_GRAB_END;
      fcba_pkg::S_CUT_RD:   cmd.op = fcba_pkg::OP_CUT_RD;
      fcba_pkg::S_CUT_WT:   cmd.op = fcba_pkg::OP_CUT_WT;
      fcba_pkg::S_FREE_RD:  if (!stat.walk_end) cmd.op = fcba_pkg::OP_FREE_RD;
      fcba_pkg::S_FREE_WT:  cmd.op = fcba_pkg::OP_WALK_WT;
      fcba_pkg::S_CUT_END:  cmd.op = fcba_pkg::OP_CUT_END;
      fcba_pkg::S_COMMIT:   cmd.op = fcba_pkg::OP_COMMIT;
      fcba_pkg::S_ACCEPT:   cmd.op = fcba_pkg::OP_PASS;
      fcba_pkg::S_DONE:     if (!stat.out_busy) cmd.op = fcba_pkg::OP_EMIT;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted item always goes to the first check.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == fcba_pkg::S_CHECK))
    else $error("accepted item did not enter the check state");

  // Starting a division makes the divider busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcba_pkg::S_DIV) |=> stat.div_busy)
    else $error("divider did not start");

  // A result handed to a free output register returns the block to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcba_pkg::S_DONE && !stat.out_busy) |=> (state_r == fcba_pkg::S_IDLE))
    else $error("result emitted without returning to idle");

  // No item is taken before the clearing sweep has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> stat.clr_done)
    else $error("item accepted during the clearing sweep");
`endif

endmodule

/* rtl/fat_chain_block_allocator.sv */
// Top level of the chained block allocator: controller, datapath and ports.
//
//  channel  | direction | handshake          | payload
//  in_ch    | in        | valid / ready      | action, file_id, amount
//  out_ch   | out       | valid / ready      | status, block_index, new_file_id
//  cfg_*    | in        | cfg_we, no wait    | cfg_idx, cfg_data
//
// One item at a time. Create and extend scan the free map from the reserved
// boundary twice (count, then link; the link pass stops once enough blocks are
// taken). The divider rounds amounts up to whole blocks, and all operations but
// create walk the chain; shrink then releases every block after the cut.
// After reset a sweep clears the free map and directory sizes; no item is
// accepted until it ends.
// The output register holds a result while the next item is already taken.
module fat_chain_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  fcba_in_if.sink                         in_ch,
  fcba_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [fcba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fcba_pkg::CFG_DATA_W-1:0] cfg_data
);

  fcba_pkg::dp_cmd_t  cmd;
  fcba_pkg::dp_stat_t stat;

  fcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcba_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_action       (in_ch.action),
    .in_file_id      (in_ch.file_id),
    .in_amount       (in_ch.amount),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_block_index (out_ch.block_index),
    .out_new_file_id (out_ch.new_file_id)
  );

endmodule

/* tb/fcba_checker.sv */
// Result checker for the chained block allocator: tracks the allocation state and compares results.
module fcba_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  fcba_in_if                              in_ch,
  fcba_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [fcba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fcba_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import fcba_pkg::*;

  localparam int NBLK = TOTAL_BLOCKS;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] blk;
    logic [FID_W-1:0] nid;
  } alloc_result_t;

  // Shadow copy of the allocation table, directory and registers.
  int          link_of [NBLK];
  bit          is_free [NBLK];
  int          first_blk [MAX_FILES];
  longint      file_bytes [MAX_FILES];
  int          blocks_used;
  int          id_next;
  int          blk_bytes;
  int          rsv_cnt;
  alloc_result_t answers_q[$];

  function automatic int unit_bytes();
    return (blk_bytes == 0) ? 1 : blk_bytes;
  endfunction

  function automatic longint bytes_to_blocks(longint bytes);
    return (bytes + unit_bytes() - 1) / unit_bytes();
  endfunction

  function automatic int scan_base();
    return (rsv_cnt < NBLK) ? rsv_cnt : NBLK;
  endfunction

  function automatic int room_left();
    int room;
    room = NBLK - scan_base();
    return (blocks_used >= room) ? 0 : room - blocks_used;
  endfunction

  function automatic int free_count();
    int n;
    n = 0;
    for (int b = scan_base(); b < NBLK; b++) n += is_free[b];
    return n;
  endfunction

  function automatic int follow(int cur, longint hops);
    if (hops > NBLK) hops = NBLK;
    for (longint i = 0; i < hops && cur < NBLK; i++) cur = link_of[cur];
    return cur;
  endfunction

  // Links n free blocks after a tail, or as a new chain; returns the new chain's first block.
  function automatic int link_free(int tail, bit has_tail, longint n);
    int first;
    first = 0;
    for (int b = scan_base(); b < NBLK && n > 0; b++) begin
      if (is_free[b]) begin
        is_free[b] = 0;
        if (has_tail) begin
          if (tail < NBLK) link_of[tail] = b;
        end else begin
          first = b;
        end
        tail = b;
        has_tail = 1;
        n--;
      end
    end
    if (has_tail && tail < NBLK) link_of[tail] = NBLK;
    return first;
  endfunction

  function automatic bit file_exists(int id);
    return id < MAX_FILES && file_bytes[id] != 0;
  endfunction

  // Applies one request to the shadow state and returns its expected answer.
  function automatic alloc_result_t apply_request(action_t act, int fid, longint amt);
    alloc_result_t r;
    longint need, grown, blocks;
    int tail, last, cur, guard;
    r = '0;
    r.status = 1'b1;
    case (act)
      ACT_CREATE: begin
        need = bytes_to_blocks(amt);
        if (id_next < MAX_FILES && need <= room_left() && need <= free_count()) begin
          first_blk[id_next] = (need != 0) ? link_free(0, 0, need) : 0;
          file_bytes[id_next] = amt;
          blocks_used += int'(need);
          r.nid = id_next[FID_W-1:0];
          id_next++;
          r.status = 1'b0;
        end
      end
      ACT_EXTEND: begin
        if (amt <= room_left() && amt <= free_count() && file_exists(fid)) begin
          grown = file_bytes[fid] + amt * unit_bytes();
          if (grown <= longint'(SIZE_LIMIT)) begin
            if (amt > 0) begin
              tail = follow(first_blk[fid], bytes_to_blocks(file_bytes[fid]) - 1);
              void'(link_free(tail, 1, amt));
              blocks_used += int'(amt);
              file_bytes[fid] = grown;
            end
            r.status = 1'b0;
          end
        end
      end
      ACT_ACCESS: begin
        if (file_exists(fid) && amt <= file_bytes[fid]) begin
          need = bytes_to_blocks(amt);
          cur = follow(first_blk[fid], (need != 0) ? need - 1 : 0);
          r.blk = cur[BLK_W-1:0];
          r.status = 1'b0;
        end
      end
      default: begin
        if (file_exists(fid)) begin
          blocks = bytes_to_blocks(file_bytes[fid]);
          if (amt <= blocks - 1) begin
            last = follow(first_blk[fid], blocks - amt - 1);
            if (last < NBLK) begin
              cur = link_of[last];
              guard = 0;
              while (cur < NBLK && guard < NBLK) begin
                is_free[cur] = 1;
                cur = link_of[cur];
                guard++;
              end
              link_of[last] = NBLK;
            end
            file_bytes[fid] -= amt * unit_bytes();
            blocks_used = (blocks_used >= amt) ? blocks_used - int'(amt) : 0;
            r.status = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Track requests, register writes and results at each clock edge.
  always @(posedge clk) begin
    alloc_result_t want, got;
    if (!rst_n) begin
      for (int b = 0; b < NBLK; b++) begin
        link_of[b] = 0;
        is_free[b] = 1;
      end
      for (int f = 0; f < MAX_FILES; f++) begin
        first_blk[f] = 0;
        file_bytes[f] = 0;
      end
      blocks_used = 0;
      id_next = 0;
      blk_bytes = 1024;
      rsv_cnt = 16;
      answers_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_BLOCK_SIZE) blk_bytes = cfg_data;
        else if (cfg_idx == REG_RESERVED) rsv_cnt = cfg_data[RSV_W-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        answers_q.push_back(apply_request(action_t'(in_ch.action), in_ch.file_id,
                                          in_ch.amount));
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.blk = out_ch.block_index;
        got.nid = out_ch.new_file_id;
        if (answers_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d block %0d id %0d",
                     got.status, got.blk, got.nid);
        end else begin
          want = answers_q.pop_front();
          if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status %0d block %0d id %0d, got %0d %0d %0d",
                       want.status, want.blk, want.nid, got.status, got.blk, got.nid);
          end
        end
      end
    end
    pending = answers_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

/* tb/tb_fat_chain_block_allocator.sv */
// Testbench top for the chained block allocator: stimulus, register setup and verdict.
module tb_fat_chain_block_allocator;
  import fcba_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;
  bit calm;
  bit hold_req;

  fcba_in_if  in_ch ();
  fcba_out_if out_ch ();

  fat_chain_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  fcba_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one item and waits for it to be taken, with an occasional gap after.
  task automatic send_item(action_t act, logic [FID_W-1:0] fid, logic [AMT_W-1:0] amt);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.file_id <= fid;
    in_ch.amount <= amt;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drains all outstanding results so the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random item, mostly aimed at files that likely exist with sizes near the block size.
  task automatic send_random(int bs);
    action_t act;
    logic [FID_W-1:0] fid;
    logic [AMT_W-1:0] amt;
    act = action_t'($urandom_range(3));
    fid = ($urandom_range(9) == 0) ? FID_W'($urandom) : FID_W'($urandom_range(0, 24));
    case (act)
      ACT_CREATE: amt = AMT_W'($urandom_range(0, bs * 5));
      ACT_ACCESS: amt = AMT_W'($urandom_range(0, bs * 7));
      default:    amt = AMT_W'($urandom_range(0, 4));
    endcase
    if ($urandom_range(19) == 0) amt = AMT_W'($urandom);
    send_item(act, fid, amt);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin
    #40000000;
    $display("tb_fat_chain_block_allocator: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_BLOCK_SIZE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CREATE;
    in_ch.file_id = '0;
    in_ch.amount = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty create, one byte, several blocks, all operations.
    send_item(ACT_CREATE, 10'd0, 28'd0);
    send_item(ACT_CREATE, 10'd5, 28'd1);
    send_item(ACT_CREATE, 10'h3FF, 28'd5000);
    send_item(ACT_ACCESS, 10'd0, 28'd0);
    send_item(ACT_ACCESS, 10'd2, 28'd0);
    send_item(ACT_ACCESS, 10'd2, 28'd5000);
    send_item(ACT_ACCESS, 10'd2, 28'd5001);
    send_item(ACT_ACCESS, 10'd2, 28'd2049);
    send_item(ACT_EXTEND, 10'd1, 28'd2);
    send_item(ACT_EXTEND, 10'd1, 28'd0);
    send_item(ACT_EXTEND, 10'd1, SIZE_LIMIT);
    send_item(ACT_EXTEND, 10'h3FF, 28'd1);
    send_item(ACT_SHRINK, 10'd1, 28'd3);
    send_item(ACT_SHRINK, 10'd2, 28'd1);
    send_item(ACT_SHRINK, 10'd1, 28'd2);
    send_item(ACT_CREATE, 10'd0, SIZE_LIMIT);
    send_item(ACT_ACCESS, 10'd1, SIZE_LIMIT);
    drain();

    // Largest block size: a create too big for the store, then items on an absent file.
    write_reg(REG_BLOCK_SIZE, 16'hFFFF);
    write_reg(REG_RESERVED, 16'd4088);
    send_item(ACT_CREATE, 10'd0, 28'h0FFFFF0);
    send_item(ACT_EXTEND, 10'd3, 28'd1);
    send_item(ACT_EXTEND, 10'd3, 28'd7);
    send_item(ACT_ACCESS, 10'd3, 28'h0FFFFF0);
    drain();

    // Block size zero acts as one; top reserve leaves a single block.
    write_reg(REG_BLOCK_SIZE, 16'd0);
    write_reg(REG_RESERVED, 16'h0FFF);
    send_item(ACT_CREATE, 10'd0, 28'd2);
    send_item(ACT_CREATE, 10'd0, 28'd1);
    send_item(ACT_ACCESS, 10'd5, 28'd1);
    drain();

    // Random traffic over a small store, with a calm stretch and a long result stall.
    write_reg(REG_BLOCK_SIZE, 16'd100);
    write_reg(REG_RESERVED, 16'd4032);
    for (int i = 0; i < 60; i++) begin
      calm = (i >= 20 && i < 45);
      if (i == 50) hold_req = 1'b1;
      if (i >= 50) send_item(ACT_ACCESS, FID_W'($urandom_range(0, 24)),
                             AMT_W'($urandom_range(0, 300)));
      else send_random(100);
    end
    calm = 1'b0;
    drain();
    write_reg(REG_BLOCK_SIZE, 16'd1);
    write_reg(REG_RESERVED, 16'd4060);
    for (int i = 0; i < 56; i++) send_random(1);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_fat_chain_block_allocator: clean");
    end else begin
      $display("tb_fat_chain_block_allocator: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/fcba_pkg.sv
rtl/fcba_if.sv
rtl/fcba_div.sv
rtl/fcba_datapath.sv
rtl/fcba_ctrl.sv
rtl/fat_chain_block_allocator.sv
tb/fcba_checker.sv
tb/tb_fat_chain_block_allocator.sv
